### design/hbfe_pkg.sv
// Shared constants, codes and interface types of the histogram bin fill engine.
`timescale 1ns / 1ps

package hbfe_pkg;

    localparam int MAX_BINS    = 1024;
    localparam int STORE_DEPTH = MAX_BINS + 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BIN_W       = 11;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int FRAC_W      = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_FILL = 2'd0;
    localparam logic [OP_W-1:0] OP_SET  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_EDGE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_SCALE = 2'd2;

    localparam logic [BIN_W-1:0]  NUM_BINS_RESET = 11'd1024;
    localparam logic [DATA_W-1:0] SCALE_RESET    = 32'd65536;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic diff;
        logic mul;
        logic locate;
        logic rd;
        logic finish;
        logic clr;
    } hbfe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } hbfe_sts_t;

endpackage

### design/hbfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hbfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1026
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/hbfe_ctrl.sv
// Controller state machine that sequences clearing and each item.
`timescale 1ns / 1ps

module hbfe_ctrl
    import hbfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  hbfe_sts_t sts,
    output hbfe_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_LOC,
        S_RD,
        S_WB
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_DIFF;
            S_DIFF:  state_next = S_MUL;
            S_MUL:   state_next = S_LOC;
            S_LOC:   state_next = S_RD;
            S_RD:    state_next = S_WB;
            S_WB:    if (!sts.out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.diff   = (state_reg == S_DIFF);
    assign cmd.mul    = (state_reg == S_MUL);
    assign cmd.locate = (state_reg == S_LOC);
    assign cmd.rd     = (state_reg == S_RD);
    assign cmd.finish = (state_reg == S_WB) && !sts.out_busy;
    assign cmd.clr    = (state_reg == S_CLEAR);

endmodule

### design/hbfe_dpath.sv
// Datapath: configuration, bin location, bin store and result register.
`timescale 1ns / 1ps

module hbfe_dpath
    import hbfe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  hbfe_cmd_t                cmd,
    output hbfe_sts_t                sts,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0] position,
    input  logic [BIN_W-1:0]         bin_select,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [BIN_W-1:0]         bin_index,
    output logic signed [DATA_W-1:0] content,
    output logic                     accepted
);

    // Configuration.
    logic [BIN_W-1:0]         num_bins_reg;
    logic signed [DATA_W-1:0] low_edge_reg;
    logic [DATA_W-1:0]        scale_reg;

    // Item registers.
    logic [OP_W-1:0]          op_reg;
    logic signed [DATA_W-1:0] pos_reg;
    logic [BIN_W-1:0]         sel_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W:0]   diff_reg;
    logic [2*DATA_W-1:0]      prod_reg;
    logic                     neg_reg;
    logic [BIN_W-1:0]         idx_reg;
    logic                     ok_reg;

    // Result register.
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [BIN_W-1:0]         out_idx_reg;
    logic signed [DATA_W-1:0] out_content_reg;
    logic                     out_ok_reg;

    logic [ADDR_W-1:0]        clr_cnt_reg;

    logic [BIN_W-1:0]         nb;
    logic signed [DATA_W:0]   diff_next;
    logic [2*DATA_W-1:0]      prod_next;
    logic [BIN_W-1:0]         idx_next;
    logic                     ok_next;
    logic signed [DATA_W:0]   sum;
    logic signed [DATA_W-1:0] sum_sat;
    logic signed [DATA_W-1:0] content_next;
    logic                     store_wr;
    logic                     ram_wr_en;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic [DATA_W-1:0]        ram_wr_data;
    logic                     ram_rd_en;
    logic [DATA_W-1:0]        ram_rd_data;

    // Effective bin count: zero counts as one, large values are clamped.
    always_comb
    begin
        priority if (num_bins_reg == '0)
            nb = BIN_W'(1);
        else if (num_bins_reg > BIN_W'(MAX_BINS))
            nb = BIN_W'(MAX_BINS);
        else
            nb = num_bins_reg;
    end

    assign diff_next = {pos_reg[DATA_W-1], pos_reg} - {low_edge_reg[DATA_W-1], low_edge_reg};
    // A non-negative difference fits in DATA_W unsigned bits.
    assign prod_next = (2*DATA_W)'(diff_reg[DATA_W-1:0]) * (2*DATA_W)'(scale_reg);

    always_comb
    begin
        idx_next = sel_reg;
        ok_next  = 1'b0;
        unique case (op_reg)
            OP_FILL:
            begin
                ok_next = 1'b1;
                priority if (neg_reg)
                    idx_next = '0;
                else if (prod_reg[2*DATA_W-1:FRAC_W] >= (2*DATA_W-FRAC_W)'(nb))
                    idx_next = nb + BIN_W'(1);
                else
                    idx_next = prod_reg[FRAC_W +: BIN_W] + BIN_W'(1);
            end
            OP_SET:  ok_next = (sel_reg != '0) && (sel_reg <= nb);
            OP_READ: ok_next = (sel_reg <= nb + BIN_W'(1));
            default: ok_next = 1'b0;
        endcase
    end

    // Saturating add of the weight to the stored count.
    assign sum = {ram_rd_data[DATA_W-1], ram_rd_data} + {val_reg[DATA_W-1], val_reg};
    always_comb
    begin
        priority if (sum[DATA_W] && !sum[DATA_W-1])
            sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else if (!sum[DATA_W] && sum[DATA_W-1])
            sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
        else
            sum_sat = sum[DATA_W-1:0];
    end

    always_comb
    begin
        content_next = '0;
        unique case (op_reg)
            OP_FILL: content_next = sum_sat;
            OP_SET:  content_next = ok_reg ? val_reg : '0;
            OP_READ: content_next = ok_reg ? ram_rd_data : '0;
            default: content_next = '0;
        endcase
    end

    assign store_wr    = cmd.finish && ((op_reg == OP_FILL) || ((op_reg == OP_SET) && ok_reg));
    assign ram_wr_en   = cmd.clr || store_wr;
    assign ram_wr_addr = cmd.clr ? clr_cnt_reg : ADDR_W'(idx_reg);
    assign ram_wr_data = cmd.clr ? '0 : ((op_reg == OP_FILL) ? sum_sat : val_reg);
    assign ram_rd_en   = cmd.rd && ((op_reg == OP_FILL) || ((op_reg == OP_READ) && ok_reg));

    hbfe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ADDR_W'(idx_reg)),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bins_reg  <= NUM_BINS_RESET;
            low_edge_reg  <= '0;
            scale_reg     <= SCALE_RESET;
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_NUM_BINS)
                    num_bins_reg <= cfg_data[BIN_W-1:0];
                if (cfg_index == CFG_LOW_EDGE)
                    low_edge_reg <= cfg_data;
                if (cfg_index == CFG_BINS_SCALE)
                    scale_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
            if (cmd.clr)
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            sel_reg <= bin_select;
            val_reg <= value;
        end
        if (cmd.diff)
            diff_reg <= diff_next;
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            neg_reg  <= diff_reg[DATA_W];
        end
        if (cmd.locate)
        begin
            idx_reg <= idx_next;
            ok_reg  <= ok_next;
        end
        if (cmd.finish)
        begin
            out_idx_reg     <= idx_reg;
            out_content_reg <= content_next;
            out_ok_reg      <= ok_reg;
        end
    end

    assign sts.clr_last = (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1));
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign bin_index = out_idx_reg;
    assign content   = out_content_reg;
    assign accepted  = out_ok_reg;

endmodule

### design/histogram_bin_fill_engine_unit.sv
// Top level of the histogram bin fill engine: controller plus datapath.
`timescale 1ns / 1ps
// An item is loaded, then passes the difference, multiply, locate, store read and
// write-back steps one after another; its result beat is registered at write-back.
// No new item is taken until the current one has left write-back, and a stalled
// result holds the next item back at write-back.
// Reset: configuration returns to its defaults, then a clearing pass zeroes the
// 1026-entry bin store; no input beat is taken until it ends.
module histogram_bin_fill_engine_unit
    import hbfe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0] position,
    input  logic [BIN_W-1:0]         bin_select,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [BIN_W-1:0]         bin_index,
    output logic signed [DATA_W-1:0] content,
    output logic                     accepted,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    hbfe_cmd_t cmd;
    hbfe_sts_t sts;

    // Configuration writes are registered directly, so the port never stalls.
    assign cfg_ready = 1'b1;

    // The controller walks each item through difference, multiply, bin location,
    // store read and write-back; it also runs the clearing pass after reset.
    hbfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the bin store and the result
    // register, which lets a finished beat wait while the controller returns to idle.
    hbfe_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .opcode     (opcode),
        .position   (position),
        .bin_select (bin_select),
        .value      (value),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bin_index  (bin_index),
        .content    (content),
        .accepted   (accepted)
    );

endmodule
